// ----- design/fragment_frame_decoder_core_macros.svh -----
// Assertion macros shared by the fragment frame decoder RTL.
// Depends on nothing; included inside module bodies that assert.
`ifndef FRAGMENT_FRAME_DECODER_CORE_MACROS_SVH
`define FRAGMENT_FRAME_DECODER_CORE_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define FFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fragment frame decoder check failed");

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define FFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fragment frame decoder check failed");

`endif

// ----- design/ffd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the fragment frame decoder.
// No dependencies; imported by every module of the block.
package ffd_pkg;

   // Input transfer payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result transfer payload
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_done;
      logic [1:0]  error_code;
      logic [15:0] sequence_number;
      logic [15:0] total_count;
      logic [63:0] id_low_half;
      logic [63:0] id_high_half;
      logic [5:0]  payload_length;
      logic [7:0]  received_check;
   } rsp_type;

   // Configuration seen by the decode logic
   typedef struct packed {
      logic [31:0] signature_word;
      logic [7:0]  crc_polynomial;
   } cfg_type;

   // Error codes
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_TOO_SHORT = 2'd1;
   localparam logic [1:0] ERR_SIGNATURE = 2'd2;
   localparam logic [1:0] ERR_CRC       = 2'd3;

   // Register map: index is address bit 2
   localparam int         CSR_ADDR_W    = 3;
   localparam logic       REG_SIGNATURE = 1'b0;
   localparam logic       REG_POLY      = 1'b1;
   localparam logic [31:0] SIGNATURE_RESET = 32'h0000_0000;
   localparam logic [7:0]  POLY_RESET      = 8'h07;

   // Frame layout
   localparam int         SIG_BYTES    = 4;
   localparam int         ID_POS       = 4;
   localparam int         ID_BYTES     = 16;
   localparam int         SEQ_POS      = 20;
   localparam int         TOTAL_POS    = 22;
   localparam int         HEADER_BYTES = 24;
   localparam logic [15:0] POS_MAX     = 16'hFFFF;
   localparam logic [7:0]  CRC_INIT    = 8'h00;

   // MSB-first CRC-8 update over one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- design/ffd_csr.sv -----
// APB-style configuration registers: signature word and CRC polynomial.
// Depends on ffd_pkg.
module ffd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ffd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output ffd_pkg::cfg_type              cfg
);
   import ffd_pkg::*;

   logic [31:0] signature_ff;
   logic [7:0]  poly_ff;
   logic        write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   // Take register writes in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         signature_ff <= SIGNATURE_RESET;
         poly_ff      <= POLY_RESET;
      end else if (write_en) begin
         case (paddr[2])
            REG_SIGNATURE: signature_ff <= pwdata;
            REG_POLY:      poly_ff      <= pwdata[7:0];
            default:       ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         REG_SIGNATURE: prdata = signature_ff;
         REG_POLY:      prdata = {24'd0, poly_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.signature_word = signature_ff;
   assign cfg.crc_polynomial = poly_ff;

endmodule

// ----- design/ffd_deframer.sv -----
// Frame state and combinational byte decode: signature, header capture, CRC, status.
// Depends on ffd_pkg.
module ffd_deframer #(
   parameter int MaxPayload = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  ffd_pkg::req_type item,
   input  ffd_pkg::cfg_type cfg,
   output ffd_pkg::rsp_type result
);
   import ffd_pkg::*;

   localparam logic [15:0] CrcPos = 16'(HEADER_BYTES + MaxPayload);
   localparam logic [15:0] MaxLen = 16'(MaxPayload);

   logic [15:0]      byte_position_ff, byte_position_in;
   logic [7:0]       running_crc_ff, running_crc_in;
   logic [7:0]       held_byte_ff, held_byte_in;
   logic             signature_ok_ff, signature_ok_in;
   logic             check_latched_ff, check_latched_in;
   logic             check_matched_ff, check_matched_in;
   logic [7:0]       check_byte_ff, check_byte_in;
   logic [1:0][63:0] id_store_ff, id_store_in;
   logic [15:0]      sequence_store_ff, sequence_store_in;
   logic [15:0]      total_store_ff, total_store_in;

   logic [15:0] p;
   logic [7:0]  b;
   logic [15:0] plen_full;
   logic [3:0]  id_off;

   assign p         = byte_position_ff;
   assign b         = item.data_byte;
   assign plen_full = p - 16'(HEADER_BYTES);
   // Byte offset within the id field: bit 3 picks the word, bits 2:0 the byte lane
   assign id_off    = 4'(p - 16'(ID_POS));

   // Decode one byte against the current frame state
   always_comb begin
      byte_position_in  = byte_position_ff;
      running_crc_in    = running_crc_ff;
      held_byte_in      = held_byte_ff;
      signature_ok_in   = signature_ok_ff;
      check_latched_in  = check_latched_ff;
      check_matched_in  = check_matched_ff;
      check_byte_in     = check_byte_ff;
      id_store_in       = id_store_ff;
      sequence_store_in = sequence_store_ff;
      total_store_in    = total_store_ff;
      result            = '0;

      // Release the payload byte held from the previous transfer
      if (p >= 16'(HEADER_BYTES + 1) && p <= CrcPos) begin
         result.payload_byte  = held_byte_ff;
         result.payload_valid = 1'b1;
      end

      // Ignore everything after the CRC byte
      if (!check_latched_ff) begin
         if (p >= 16'(HEADER_BYTES) && (p == CrcPos || item.last_byte)) begin
            check_latched_in = 1'b1;
            check_matched_in = (b == running_crc_ff);
            check_byte_in    = b;
         end else begin
            running_crc_in = crc8_byte(running_crc_ff, b, cfg.crc_polynomial);
            if (p < 16'(SIG_BYTES)) begin
               if (b != cfg.signature_word[{p[1:0], 3'b000} +: 8]) begin
                  signature_ok_in = 1'b0;
               end
            end else if (p < 16'(SEQ_POS)) begin
               id_store_in[id_off[3]][{id_off[2:0], 3'b000} +: 8] = b;
            end else if (p == 16'(SEQ_POS)) begin
               sequence_store_in[7:0] = b;
            end else if (p == 16'(SEQ_POS + 1)) begin
               sequence_store_in[15:8] = b;
            end else if (p == 16'(TOTAL_POS)) begin
               total_store_in[7:0] = b;
            end else if (p == 16'(TOTAL_POS + 1)) begin
               total_store_in[15:8] = b;
            end else begin
               held_byte_in = b;
            end
         end
      end

      // Report status on the last byte, then restart the frame
      if (item.last_byte) begin
         result.frame_done = 1'b1;
         if (p < 16'(HEADER_BYTES)) begin
            result.error_code = ERR_TOO_SHORT;
         end else begin
            if (!signature_ok_in) begin
               result.error_code = ERR_SIGNATURE;
            end else if (!check_matched_in) begin
               result.error_code = ERR_CRC;
            end else begin
               result.error_code = ERR_OK;
            end
            result.sequence_number = sequence_store_in;
            result.total_count     = total_store_in;
            result.id_low_half     = id_store_in[0];
            result.id_high_half    = id_store_in[1];
            result.payload_length  = (plen_full > MaxLen) ? MaxLen[5:0] : plen_full[5:0];
            result.received_check  = check_byte_in;
         end
         byte_position_in = '0;
         running_crc_in   = CRC_INIT;
         held_byte_in     = '0;
         signature_ok_in  = 1'b1;
         check_latched_in = 1'b0;
         check_matched_in = 1'b0;
         check_byte_in    = '0;
      end else if (p != POS_MAX) begin
         byte_position_in = p + 16'd1;
      end
   end

   // Advance frame state on each decoded transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         running_crc_ff    <= CRC_INIT;
         held_byte_ff      <= '0;
         signature_ok_ff   <= 1'b1;
         check_latched_ff  <= 1'b0;
         check_matched_ff  <= 1'b0;
         check_byte_ff     <= '0;
         id_store_ff       <= '0;
         sequence_store_ff <= '0;
         total_store_ff    <= '0;
      end else if (item_fire) begin
         byte_position_ff  <= byte_position_in;
         running_crc_ff    <= running_crc_in;
         held_byte_ff      <= held_byte_in;
         signature_ok_ff   <= signature_ok_in;
         check_latched_ff  <= check_latched_in;
         check_matched_ff  <= check_matched_in;
         check_byte_ff     <= check_byte_in;
         id_store_ff       <= id_store_in;
         sequence_store_ff <= sequence_store_in;
         total_store_ff    <= total_store_in;
      end
   end

endmodule

// ----- design/fragment_frame_decoder_core.sv -----
// Fragment frame decoder: takes one frame byte per transfer and returns exactly one
// result per byte, through input register, decode and result register, sustaining one
// byte per clock while the result channel is not stalled, since the byte-wide CRC-8
// update and the frame counter are combinational. Payload bytes come out one transfer
// late; the result for the last byte carries status and, for a full header, the decoded
// header. Depends on ffd_pkg, ffd_csr, ffd_deframer and the shared assertion macros.
module fragment_frame_decoder_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ffd_pkg::req_type              req_payload,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ffd_pkg::rsp_type              rsp_payload,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ffd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ffd_pkg::*;
   `include "fragment_frame_decoder_core_macros.svh"

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type decoded;
   cfg_type cfg;
   logic    req_fire;
   logic    advance;

   ffd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ffd_deframer #(
      .MaxPayload (MAX_PAYLOAD)
   ) u_deframer (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_data_ff),
      .cfg       (cfg),
      .result    (decoded)
   );

   // Move the held byte into the result register when that register frees up
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= decoded;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // A decoded byte always lands in the result register
   `FFD_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   // A blocked input byte is kept, not dropped
   `FFD_ASSERT_NEXT(a_blocked_input_kept, clock, reset,
      in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff)
   // Status only shows on the last byte of a frame
   `FFD_ASSERT_SAME(a_status_only_at_end, clock, reset,
      out_valid_ff && !out_data_ff.frame_done,
      out_data_ff.error_code == ERR_OK && out_data_ff.received_check == 8'd0)
   // A short frame reports no decoded fields
   `FFD_ASSERT_SAME(a_short_frame_clear, clock, reset,
      out_valid_ff && out_data_ff.frame_done && out_data_ff.error_code == ERR_TOO_SHORT,
      out_data_ff.payload_length == 6'd0 && out_data_ff.sequence_number == 16'd0)

endmodule

// ----- bench/fragment_frame_decoder_core_tb.sv -----
// Self-checking bench for fragment_frame_decoder_core: frames are built and driven one byte
// per transfer, and every result is checked against a cycle-free decode of the same bytes.
// Depends on ffd_pkg for the transfer types, error codes, register map and frame layout.
module fragment_frame_decoder_core_tb;
   import ffd_pkg::*;

   localparam int MAX_PAYLOAD = 32;
   localparam int CRC_POS     = HEADER_BYTES + MAX_PAYLOAD;
   localparam int MIN_FRAME   = HEADER_BYTES + 1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SIGNATURE = {REG_SIGNATURE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_POLY      = {REG_POLY, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   fragment_frame_decoder_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the configuration registers
   logic [31:0] sig_cfg;
   logic [7:0]  poly_cfg;

   // Shadow of the decoder's frame state and header stores
   logic [15:0] pos_cnt;
   logic [7:0]  crc_acc;
   logic [7:0]  held_payload;
   logic        sig_good;
   logic        crc_seen;
   logic        crc_good;
   logic [7:0]  crc_rx;
   logic [63:0] id_words [2];
   logic [15:0] seq_word;
   logic [15:0] total_word;

   rsp_type decoded_q [$];

   bit idle_on = 1'b1;
   int mismatch_count = 0;
   int checked_count = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", decoded_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Decode model
   // ---------------------------------------------------------------------
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly_cfg) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   task automatic restart_frame();
      pos_cnt = '0;
      crc_acc = CRC_INIT;
      held_payload = '0;
      sig_good = 1'b1;
      crc_seen = 1'b0;
      crc_good = 1'b0;
      crc_rx = '0;
   endtask

   task automatic decoder_reset();
      sig_cfg = SIGNATURE_RESET;
      poly_cfg = POLY_RESET;
      restart_frame();
      id_words[0] = '0;
      id_words[1] = '0;
      seq_word = '0;
      total_word = '0;
   endtask

   // Decode one byte into the result it causes and advance the frame state
   task automatic deframe_step(input logic [7:0] b, input logic last, output rsp_type res);
      int unsigned p;
      int unsigned q;
      int unsigned plen;
      p = pos_cnt;
      res = '0;
      // release the payload byte held from the previous transfer
      if (p >= HEADER_BYTES + 1 && p <= CRC_POS) begin
         res.payload_byte = held_payload;
         res.payload_valid = 1'b1;
      end
      if (!crc_seen) begin
         if (p >= HEADER_BYTES && (p == CRC_POS || last)) begin
            crc_seen = 1'b1;
            crc_good = (b == crc_acc);
            crc_rx = b;
         end else begin
            crc_acc = crc8_next(crc_acc, b);
            if (p < SIG_BYTES) begin
               if (b != sig_cfg[8*p +: 8]) sig_good = 1'b0;
            end else if (p < SEQ_POS) begin
               q = p - ID_POS;
               id_words[q / 8][8 * (q % 8) +: 8] = b;
            end else if (p == SEQ_POS) begin
               seq_word[7:0] = b;
            end else if (p == SEQ_POS + 1) begin
               seq_word[15:8] = b;
            end else if (p == TOTAL_POS) begin
               total_word[7:0] = b;
            end else if (p == TOTAL_POS + 1) begin
               total_word[15:8] = b;
            end else begin
               held_payload = b;
            end
         end
      end
      if (last) begin
         res.frame_done = 1'b1;
         if (p + 1 < MIN_FRAME) begin
            res.error_code = ERR_TOO_SHORT;
         end else begin
            plen = p - HEADER_BYTES;
            if (plen > MAX_PAYLOAD) plen = MAX_PAYLOAD;
            if (!sig_good) res.error_code = ERR_SIGNATURE;
            else if (!crc_good) res.error_code = ERR_CRC;
            else res.error_code = ERR_OK;
            res.sequence_number = seq_word;
            res.total_count = total_word;
            res.id_low_half = id_words[0];
            res.id_high_half = id_words[1];
            res.payload_length = plen[5:0];
            res.received_check = crc_rx;
         end
         restart_frame();
      end else if (pos_cnt != POS_MAX) begin
         pos_cnt = pos_cnt + 16'd1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at result %0d: %0s got %0h want %0h", checked_count, what, got,
                  want);
      end
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if (got.payload_byte !== want.payload_byte)
         report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
      if (got.payload_valid !== want.payload_valid)
         report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
      if (got.frame_done !== want.frame_done)
         report_mismatch("frame_done", got.frame_done, want.frame_done);
      if (got.error_code !== want.error_code)
         report_mismatch("error_code", got.error_code, want.error_code);
      if (got.sequence_number !== want.sequence_number)
         report_mismatch("sequence_number", got.sequence_number, want.sequence_number);
      if (got.total_count !== want.total_count)
         report_mismatch("total_count", got.total_count, want.total_count);
      if (got.id_low_half !== want.id_low_half)
         report_mismatch("id_low_half", got.id_low_half, want.id_low_half);
      if (got.id_high_half !== want.id_high_half)
         report_mismatch("id_high_half", got.id_high_half, want.id_high_half);
      if (got.payload_length !== want.payload_length)
         report_mismatch("payload_length", got.payload_length, want.payload_length);
      if (got.received_check !== want.received_check)
         report_mismatch("received_check", got.received_check, want.received_check);
   endtask

   // Check each result transfer against the oldest decoded result
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_payload[63:0], '0);
         end else begin
            compare_result(rsp_payload, decoded_q.pop_front());
         end
         checked_count++;
      end
   end

   // Stall the result channel in random bursts, only while idling is on
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!rsp_stall && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Send one byte, with an optional gap first; valid stays high afterwards
   task automatic send_byte(input logic [7:0] b, input logic last);
      rsp_type res;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
      deframe_step(b, last, res);
      decoded_q.push_back(res);
      bytes_sent++;
      if (last) frames_sent++;
   endtask

   // Hold off until every outstanding result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_SIGNATURE) sig_cfg = data;
      else if (addr == ADDR_POLY) poly_cfg = data[7:0];
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) report_mismatch("register read back", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Change both registers while the decoder is idle, then read them back
   task automatic set_config(input logic [31:0] sig, input logic [7:0] poly);
      drain();
      csr_write(ADDR_SIGNATURE, sig);
      csr_write(ADDR_POLY, {24'd0, poly});
      csr_check(ADDR_SIGNATURE, sig_cfg);
      csr_check(ADDR_POLY, {24'd0, poly_cfg});
   endtask

   // Build and send one frame: signature, random header, payload, CRC, trailing bytes.
   // Trailing bytes only follow a full payload, where the CRC byte is not the last one.
   task automatic send_frame(input int plen, input int extra, input bit sig_bad,
                             input bit crc_bad);
      logic [7:0] bytes [$];
      logic [7:0] crc;
      int bad_at;
      bad_at = $urandom_range(0, SIG_BYTES - 1);
      for (int i = 0; i < SIG_BYTES; i++) begin
         bytes.push_back(sig_cfg[8*i +: 8] ^ ((sig_bad && i == bad_at) ?
                         8'($urandom_range(1, 255)) : 8'h00));
      end
      for (int i = SIG_BYTES; i < HEADER_BYTES + plen; i++) begin
         bytes.push_back(8'($urandom));
      end
      crc = CRC_INIT;
      foreach (bytes[i]) crc = crc8_next(crc, bytes[i]);
      bytes.push_back(crc ^ (crc_bad ? 8'($urandom_range(1, 255)) : 8'h00));
      if (plen == MAX_PAYLOAD) begin
         for (int i = 0; i < extra; i++) bytes.push_back(8'($urandom));
      end
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // Random bytes with the last flag on the final one
   task automatic send_noise(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_defaults();
      csr_check(ADDR_SIGNATURE, SIGNATURE_RESET);
      csr_check(ADDR_POLY, {24'd0, POLY_RESET});
      send_frame(0, 0, 1'b0, 1'b0);
      send_frame(3, 0, 1'b0, 1'b0);
   endtask

   task automatic test_short_frames();
      send_noise(1);
      send_noise(MIN_FRAME - 1);
   endtask

   task automatic test_payload_extremes();
      set_config(32'hFFFF_FFFF, 8'hFF);
      send_frame(0, 0, 1'b0, 1'b0);
      send_frame(MAX_PAYLOAD, 0, 1'b0, 1'b0);
      // bytes after the CRC byte are ignored
      send_frame(MAX_PAYLOAD, 3, 1'b0, 1'b0);
   endtask

   task automatic test_error_priority();
      set_config(32'h1234_5678, 8'h1D);
      send_frame(5, 0, 1'b1, 1'b1);
      send_frame(5, 0, 1'b0, 1'b1);
      send_frame(5, 0, 1'b1, 1'b0);
      send_frame(MAX_PAYLOAD, 2, 1'b0, 1'b1);
   endtask

   task automatic random_phase(input int byte_goal, input bit allow_idle);
      int start;
      int kind;
      int plen;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         idle_on = allow_idle && ($urandom_range(0, 4) != 0);
         kind = $urandom_range(0, 99);
         plen = ($urandom_range(0, 3) == 0) ? MAX_PAYLOAD : $urandom_range(0, MAX_PAYLOAD);
         if (kind < 70) send_frame(plen, $urandom_range(0, 4), 1'b0, 1'b0);
         else if (kind < 80) send_frame(plen, $urandom_range(0, 2), 1'b0, 1'b1);
         else if (kind < 90) send_frame(plen, 0, 1'b1, $urandom_range(0, 1));
         else if (kind < 95) send_noise($urandom_range(1, MIN_FRAME - 1));
         else send_noise($urandom_range(1, 70));
      end
      idle_on = allow_idle;
   endtask

   task automatic test_random_traffic();
      set_config($urandom, 8'($urandom));
      random_phase(200, 1'b1);
      set_config($urandom, 8'h00);
      random_phase(200, 1'b1);
      set_config(32'h0000_0000, 8'($urandom));
      random_phase(200, 1'b1);
      // last stretch runs without any idling
      set_config($urandom, POLY_RESET);
      random_phase(200, 1'b0);
   endtask

   initial begin
      decoder_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_short_frames();
      test_payload_extremes();
      test_error_priority();
      test_random_traffic();
      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d frames in %0d bytes, %0d results checked, %0d mismatches",
               frames_sent, bytes_sent, checked_count, mismatch_count);
      $display("signature, payload length, trailing byte and CRC cases under several "
               , "register values");
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
